// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ogru_pkg.sv =====
// ---------------------------------------------------------------------------
// ogru_pkg
// Shared constants, types and helpers of the occupancy grid ray update unit.
// ---------------------------------------------------------------------------
package ogru_pkg;

    localparam int GRID_W     = 128;
    localparam int GRID_H     = 128;
    localparam int CELL_COUNT = GRID_W * GRID_H;
    localparam int GRID_XW    = $clog2(GRID_W);
    localparam int GRID_YW    = $clog2(GRID_H);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int COORD_W = 11;
    localparam int DW      = COORD_W + 1;
    localparam int ERR_W   = COORD_W + 2;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 11;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = ((4 * COORD_W + 7) / 8) * 8;
    localparam int S_PAD_W   = S_TDATA_W - 4 * COORD_W;
    localparam int M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - VAL_W - CNT_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FREE_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_INC  = 2'd1;

    localparam logic signed [VAL_W-1:0] FREE_INC_RST = -16'sd104;
    localparam logic signed [VAL_W-1:0] OCC_INC_RST  = 16'sd217;

    localparam logic signed [COORD_W:0] GRID_W_S = (COORD_W + 1)'(GRID_W);
    localparam logic signed [COORD_W:0] GRID_H_S = (COORD_W + 1)'(GRID_H);
    localparam logic [ADDR_W-1:0]       CLR_LAST = ADDR_W'(CELL_COUNT - 1);

    typedef struct packed {
        logic [FUNC_W-1:0]         op;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic [DW-1:0]             dx;
        logic [DW-1:0]             dy;
        logic                      xpos;
        logic                      ypos;
        logic signed [ERR_W-1:0]   err0;
        logic                      hit_in;
        logic [ADDR_W-1:0]         hit_addr;
    } ray_cmd_t;

    typedef struct packed {
        logic     valid;
        ray_cmd_t cmd;
    } front_to_back_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_to_front_t;

    function automatic logic in_grid(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
        logic x_ok;
        logic y_ok;
        x_ok = !x[COORD_W-1] && ($signed({x[COORD_W-1], x}) < GRID_W_S);
        y_ok = !y[COORD_W-1] && ($signed({y[COORD_W-1], y}) < GRID_H_S);
        return x_ok && y_ok;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        row = ADDR_W'(y[GRID_YW-1:0]);
        col = ADDR_W'(x[GRID_XW-1:0]);
        return ADDR_W'(row * ADDR_W'(GRID_W)) + col;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return s[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/occupancy_grid_ray_update_unit.sv =====
// ---------------------------------------------------------------------------
// occupancy_grid_ray_update_unit
// Log-odds occupancy grid with Bresenham ray update, cell read and map clear.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// s_*       in         s_tvalid/s_tready    tdata: coordinates, tuser: func
// m_*       out        m_tvalid/m_tready    tdata: value, count; tuser: hit
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Update walks one cell per cycle through the single grid RAM read/write port
// pair. After reset a sweep zeroes all 16384 cells; s_tready stays low meanwhile.
// A two-entry request queue lets intake continue while the result is stalled.
// ---------------------------------------------------------------------------
module occupancy_grid_ray_update_unit
    import ogru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sensor_x, sensor_y, target_x, target_y
    input  logic [FUNC_W-1:0]    s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // cell_value, cells_marked_free
    output logic [0:0]           m_tuser,   // hit_inside
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    front_to_back_t fb;
    back_to_front_t bf;

    ogru_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fb       (fb),
        .bf       (bf)
    );

    ogru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fb        (fb),
        .bf        (bf),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/ogru_ram.sv =====
// ---------------------------------------------------------------------------
// ogru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ogru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ogru_front.sv =====
// ---------------------------------------------------------------------------
// ogru_front
// Request intake: unpacks, derives ray setup terms, queues for the back end.
// ---------------------------------------------------------------------------
module ogru_front
    import ogru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]    s_tuser,
    output front_to_back_t       fb,
    input  back_to_front_t       bf
);

    ray_cmd_t            q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    ray_cmd_t                cmd;
    logic signed [DW-1:0]    diff_x;
    logic signed [DW-1:0]    diff_y;
    logic                    push;
    logic                    pop;

    assign s_tready = (count_reg != QCNT_W'(QDEPTH)) && !bf.init_busy;
    assign push     = s_tvalid && s_tready;
    assign pop      = bf.pop && (count_reg != '0);

    always_comb
    begin
        cmd.op = s_tuser;
        cmd.sx = s_tdata[COORD_W-1:0];
        cmd.sy = s_tdata[2*COORD_W-1:COORD_W];
        cmd.tx = s_tdata[3*COORD_W-1:2*COORD_W];
        cmd.ty = s_tdata[4*COORD_W-1:3*COORD_W];
        diff_x = $signed({cmd.tx[COORD_W-1], cmd.tx}) - $signed({cmd.sx[COORD_W-1], cmd.sx});
        diff_y = $signed({cmd.ty[COORD_W-1], cmd.ty}) - $signed({cmd.sy[COORD_W-1], cmd.sy});
        cmd.dx   = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        cmd.dy   = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
        cmd.xpos = cmd.sx < cmd.tx;
        cmd.ypos = cmd.sy < cmd.ty;
        if (cmd.dx > cmd.dy)
            cmd.err0 = $signed({2'b00, cmd.dx[DW-1:1]});
        else
            cmd.err0 = -$signed({2'b00, cmd.dy[DW-1:1]});
        cmd.hit_in   = in_grid(cmd.tx, cmd.ty);
        cmd.hit_addr = cell_addr(cmd.tx, cmd.ty);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd;
        end
    end

    assign fb.valid = count_reg != '0;
    assign fb.cmd   = q_mem[rd_ptr_reg];

endmodule

// ===== rtl/ogru_back.sv =====
// ---------------------------------------------------------------------------
// ogru_back
// Execution: ray walk with read-modify-write, reads, map sweeps, result reg.
// ---------------------------------------------------------------------------
module ogru_back
    import ogru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  front_to_back_t       fb,
    output back_to_front_t       bf,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_HIT   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_RWAIT = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [ADDR_W-1:0]         clr_reg, clr_next;
    logic                      pend_reg, pend_next;
    logic                      mv_reg, mv_next;
    logic signed [VAL_W-1:0]   free_inc_reg, free_inc_next;
    logic signed [VAL_W-1:0]   occ_inc_reg, occ_inc_next;

    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] tx_reg, tx_next;
    logic signed [COORD_W-1:0] ty_reg, ty_next;
    logic [DW-1:0]             dx_reg, dx_next;
    logic [DW-1:0]             dy_reg, dy_next;
    logic                      xpos_reg, xpos_next;
    logic                      ypos_reg, ypos_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic                      hin_reg, hin_next;
    logic [ADDR_W-1:0]         haddr_reg, haddr_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;
    logic                      rhit_reg, rhit_next;
    logic [ADDR_W-1:0]         paddr_reg, paddr_next;
    logic signed [VAL_W-1:0]   pinc_reg, pinc_next;
    logic [M_TDATA_W-1:0]      mdata_reg, mdata_next;
    logic                      muser_reg, muser_next;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [VAL_W-1:0]          ram_wdata;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VAL_W-1:0]          ram_rdata;
    logic signed [ERR_W-1:0]   dx_s;
    logic signed [ERR_W-1:0]   dy_s;
    logic                      step_x;
    logic                      step_y;
    logic                      pop;

    ogru_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready    = 1'b1;
    assign bf.pop       = pop;
    assign bf.init_busy = state_reg == {1'b0, S_INIT};
    assign m_tvalid     = mv_reg;
    assign m_tdata      = mdata_reg;
    assign m_tuser      = muser_reg;

    assign dx_s   = $signed({1'b0, dx_reg});
    assign dy_s   = $signed({1'b0, dy_reg});
    assign step_x = err_reg > -dx_s;
    assign step_y = err_reg < dy_s;

    // write port: pending read-modify-write first, else sweep
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = paddr_reg;
        ram_wdata = sat_add($signed(ram_rdata), pinc_reg);
        if (pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == {1'b0, S_INIT} || state_reg == {1'b0, S_CLEAR})
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pend_next     = 1'b0;
        mv_next       = mv_reg && !m_tready;
        free_inc_next = free_inc_reg;
        occ_inc_next  = occ_inc_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        xpos_next     = xpos_reg;
        ypos_next     = ypos_reg;
        err_next      = err_reg;
        hin_next      = hin_reg;
        haddr_next    = haddr_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        rhit_next     = rhit_reg;
        paddr_next    = paddr_reg;
        pinc_next     = pinc_reg;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;
        ram_re        = 1'b0;
        ram_raddr     = haddr_reg;
        pop           = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FREE_INC: free_inc_next = $signed(cfg_data);
                CFG_OCC_INC:  occ_inc_next  = $signed(cfg_data);
                default:      ;
            endcase
        end

        case (state_reg)
            {1'b0, S_INIT}:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    clr_next   = '0;
                    state_next = {1'b0, S_IDLE};
                end
            end
            {1'b0, S_IDLE}:
            begin
                if (fb.valid)
                begin
                    pop        = 1'b1;
                    x_next     = fb.cmd.sx;
                    y_next     = fb.cmd.sy;
                    tx_next    = fb.cmd.tx;
                    ty_next    = fb.cmd.ty;
                    dx_next    = fb.cmd.dx;
                    dy_next    = fb.cmd.dy;
                    xpos_next  = fb.cmd.xpos;
                    ypos_next  = fb.cmd.ypos;
                    err_next   = fb.cmd.err0;
                    hin_next   = fb.cmd.hit_in;
                    haddr_next = fb.cmd.hit_addr;
                    cnt_next   = '0;
                    val_next   = '0;
                    rhit_next  = 1'b0;
                    clr_next   = '0;
                    case (fb.cmd.op)
                        FUNC_UPDATE:
                        begin
                            rhit_next  = fb.cmd.hit_in;
                            state_next = {1'b0, S_WALK};
                        end
                        FUNC_READ:
                        begin
                            rhit_next  = fb.cmd.hit_in;
                            state_next = {1'b0, S_READ};
                        end
                        FUNC_CLEAR: state_next = {1'b0, S_CLEAR};
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            {1'b0, S_WALK}:
            begin
                if (x_reg == tx_reg && y_reg == ty_reg)
                begin
                    state_next = {1'b0, S_HIT};
                end
                else
                begin
                    if (in_grid(x_reg, y_reg))
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = cell_addr(x_reg, y_reg);
                        pend_next  = 1'b1;
                        paddr_next = cell_addr(x_reg, y_reg);
                        pinc_next  = free_inc_reg;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    err_next = err_reg - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
                    if (step_x)
                        x_next = xpos_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                    if (step_y)
                        y_next = ypos_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                end
            end
            {1'b0, S_HIT}:
            begin
                if (hin_reg)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = haddr_reg;
                    pinc_next  = occ_inc_reg;
                end
                state_next = {1'b0, S_DRAIN};
            end
            {1'b0, S_DRAIN}:
            begin
                state_next = S_OUT;
            end
            {1'b0, S_READ}:
            begin
                ram_re     = hin_reg;
                state_next = {1'b0, S_RWAIT};
            end
            {1'b0, S_RWAIT}:
            begin
                if (hin_reg)
                    val_next = $signed(ram_rdata);
                state_next = S_OUT;
            end
            {1'b0, S_CLEAR}:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    clr_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = {{M_PAD_W{1'b0}}, cnt_reg, val_reg};
                    muser_next = rhit_reg;
                    state_next = {1'b0, S_IDLE};
                end
            end
            default:
            begin
                state_next = {1'b0, S_IDLE};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= {1'b0, S_INIT};
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            mv_reg       <= 1'b0;
            free_inc_reg <= FREE_INC_RST;
            occ_inc_reg  <= OCC_INC_RST;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            mv_reg       <= mv_next;
            free_inc_reg <= free_inc_next;
            occ_inc_reg  <= occ_inc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        xpos_reg  <= xpos_next;
        ypos_reg  <= ypos_next;
        err_reg   <= err_next;
        hin_reg   <= hin_next;
        haddr_reg <= haddr_next;
        cnt_reg   <= cnt_next;
        val_reg   <= val_next;
        rhit_reg  <= rhit_next;
        paddr_reg <= paddr_next;
        pinc_reg  <= pinc_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule

// ===== rtl/ogru_checker.sv =====
// ---------------------------------------------------------------------------
// ogru_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ogru_checker
    import ogru_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [VAL_W-1:0]     cfg_data
);

    logic stalled;
    logic value_nz;
    logic count_nz;

    assign stalled  = m_tvalid && !m_tready;
    assign value_nz = m_tdata[VAL_W-1:0] != '0;
    assign count_nz = m_tdata[VAL_W+CNT_W-1:VAL_W] != '0;

    `ASSERT_NEXT(a_out_hold, stalled, m_tvalid)
    `ASSERT_NEXT(a_out_stable, stalled, $stable(m_tdata) && $stable(m_tuser))
    // a nonzero value only comes from a read inside the grid
    `ASSERT_IMPL(a_value_hit, m_tvalid && value_nz, m_tuser[0])
    // ray results never carry a cell value
    `ASSERT_IMPL(a_count_no_value, m_tvalid && count_nz, !value_nz)

endmodule

bind occupancy_grid_ray_update_unit ogru_checker u_ogru_checker (.*);
